[src/lslm_pkg.sv]
package lslm_pkg;

  localparam int SEQ_W        = 32;
  localparam int CNT_W        = 32;
  localparam int RSSI_W       = 8;
  localparam int RSSI_AVG_W   = 12;
  localparam int RSSI_SUM_W   = 16;
  localparam int RSSI_COUNT_W = 8;

  localparam int GAP_BINS     = 4;
  localparam int REPORT_BINS  = 4;
  localparam int AVG_WINDOW   = 30;
  localparam int RSSI_SCALE   = 10;

  // floor(x / AVG_WINDOW) as (x * DIV_MULT) >> DIV_SHIFT, exact for x below 2**AVG_PROD_W
  localparam int AVG_PROD_W   = RSSI_SUM_W + 4;
  localparam int WIN_LOG2     = $clog2(AVG_WINDOW);
  localparam int DIV_SHIFT    = AVG_PROD_W + WIN_LOG2;
  localparam int MULT_W       = AVG_PROD_W + 1;
  localparam int PROD_W       = AVG_PROD_W + MULT_W;
  localparam logic [MULT_W-1:0] DIV_MULT =
    MULT_W'(((longint'(1) << DIV_SHIFT) + longint'(AVG_WINDOW) - 1) / longint'(AVG_WINDOW));

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 312;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_number;
    logic [SEQ_W-1:0]  check_word;
    logic [RSSI_W-1:0] rssi;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]      expected_before;
    logic [RSSI_W-1:0]     rssi_echo;
    logic [CNT_W-1:0]      gap_bin_one;
    logic [CNT_W-1:0]      gap_bin_two;
    logic [CNT_W-1:0]      gap_bin_three;
    logic [CNT_W-1:0]      gap_bin_four;
    logic [CNT_W-1:0]      gap_bin_over;
    logic [CNT_W-1:0]      missed_total;
    logic [SEQ_W-1:0]      since_last;
    logic [CNT_W-1:0]      check_errors;
    logic [RSSI_AVG_W-1:0] rssi_average;
  } result_t;

endpackage

[src/lslm_stats.sv]
module lslm_stats (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  lslm_pkg::in_item_t item,
  output lslm_pkg::result_t  result
);
  import lslm_pkg::*;

  logic [SEQ_W-1:0]        expected_seq;
  logic [SEQ_W-1:0]        previous_expected;
  logic [CNT_W-1:0]        gap_histogram [GAP_BINS+1];
  logic [CNT_W-1:0]        missed_sum;
  logic [CNT_W-1:0]        check_fail_count;
  logic [RSSI_SUM_W-1:0]   rssi_sum;
  logic [RSSI_COUNT_W-1:0] rssi_count;
  logic [RSSI_AVG_W-1:0]   rssi_avg_reg;

  logic [SEQ_W-1:0]        held_seq;
  logic                    ahead;
  logic [SEQ_W-1:0]        gap;
  logic [SEQ_W-1:0]        gap_m1;
  logic                    in_bins;
  logic [CNT_W-1:0]        hist_next [GAP_BINS+1];
  logic [CNT_W-1:0]        shown_bins [REPORT_BINS];
  logic [CNT_W-1:0]        missed_sum_next;
  logic [CNT_W-1:0]        check_fail_count_next;
  logic [RSSI_SUM_W-1:0]   sum_add;
  logic [RSSI_COUNT_W-1:0] count_add;
  logic                    window_done;
  logic [AVG_PROD_W-1:0]   scaled;
  logic [PROD_W-1:0]       prod;
  logic [RSSI_SUM_W-1:0]   rssi_sum_next;
  logic [RSSI_COUNT_W-1:0] rssi_count_next;
  logic [RSSI_AVG_W-1:0]   rssi_avg_reg_next;

  assign held_seq = expected_seq;
  assign ahead    = item.seq_number > held_seq;
  assign gap      = item.seq_number - held_seq;
  assign gap_m1   = gap - SEQ_W'(1);
  assign in_bins  = gap_m1 < SEQ_W'(GAP_BINS);

  always_comb begin
    for (int i = 0; i < GAP_BINS; i++) begin
      hist_next[i] = gap_histogram[i] +
                     CNT_W'(ahead && in_bins && (gap_m1 == SEQ_W'(i)));
    end
    hist_next[GAP_BINS] = gap_histogram[GAP_BINS] + CNT_W'(ahead && !in_bins);
  end

  for (genvar j = 0; j < REPORT_BINS; j++) begin : g_show
    if (j < GAP_BINS) begin : g_real
      assign shown_bins[j] = hist_next[j];
    end else begin : g_none
      assign shown_bins[j] = '0;
    end
  end

  assign missed_sum_next       = ahead ? missed_sum + gap : missed_sum;
  assign check_fail_count_next = check_fail_count +
                                 CNT_W'(item.seq_number != ~item.check_word);

  // rssi window average, times ten, divided by reciprocal multiply
  assign sum_add     = rssi_sum + RSSI_SUM_W'(item.rssi);
  assign count_add   = rssi_count + RSSI_COUNT_W'(1);
  assign window_done = count_add >= RSSI_COUNT_W'(AVG_WINDOW);
  assign scaled      = (AVG_PROD_W'(sum_add) << 3) + (AVG_PROD_W'(sum_add) << 1);
  assign prod        = PROD_W'(scaled) * PROD_W'(DIV_MULT);

  assign rssi_sum_next     = window_done ? '0 : sum_add;
  assign rssi_count_next   = window_done ? '0 : count_add;
  assign rssi_avg_reg_next = window_done ? prod[DIV_SHIFT +: RSSI_AVG_W] : rssi_avg_reg;

  always_comb begin
    result.expected_before = held_seq;
    result.rssi_echo       = item.rssi;
    result.gap_bin_one     = shown_bins[0];
    result.gap_bin_two     = shown_bins[1];
    result.gap_bin_three   = shown_bins[2];
    result.gap_bin_four    = shown_bins[3];
    result.gap_bin_over    = hist_next[GAP_BINS];
    result.missed_total    = missed_sum_next;
    result.since_last      = held_seq - previous_expected;
    result.check_errors    = check_fail_count_next;
    result.rssi_average    = rssi_avg_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq      <= '0;
      previous_expected <= '0;
      for (int i = 0; i <= GAP_BINS; i++) begin
        gap_histogram[i] <= '0;
      end
      missed_sum        <= '0;
      check_fail_count  <= '0;
      rssi_sum          <= '0;
      rssi_count        <= '0;
      rssi_avg_reg      <= '0;
    end else if (adv) begin
      expected_seq      <= item.seq_number + SEQ_W'(1);
      previous_expected <= held_seq;
      for (int i = 0; i <= GAP_BINS; i++) begin
        gap_histogram[i] <= hist_next[i];
      end
      missed_sum        <= missed_sum_next;
      check_fail_count  <= check_fail_count_next;
      rssi_sum          <= rssi_sum_next;
      rssi_count        <= rssi_count_next;
      rssi_avg_reg      <= rssi_avg_reg_next;
    end
  end

`ifndef SYNTHESIS
  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    rssi_count < RSSI_COUNT_W'(AVG_WINDOW))
    else $error("rssi window count out of range");

  a_resync: assert property (@(posedge clk) disable iff (rst)
    adv |=> expected_seq == $past(item.seq_number) + SEQ_W'(1))
    else $error("expected sequence not resynced");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(check_fail_count) && $stable(missed_sum) && $stable(expected_seq))
    else $error("statistics changed without an item");
`endif

endmodule

[src/link_sequence_loss_monitor_core.sv]
// Link sequence loss monitor. Each input item is one received packet (sequence
// number, check word, signal strength); each yields exactly one result item with
// the expected number held before it, gap histogram, missed total, check error
// count and the last ten-times window average of signal strength. One item a
// cycle is sustained while the output is not back-pressured: an input register
// feeds the single-pass statistics update, whose outcome lands in an output
// register; the input side keeps accepting while a result waits, stalling only
// when both the input and output registers are full.
module link_sequence_loss_monitor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // seq_number [31:0], check_word [63:32], rssi [71:64]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // expected_before [31:0], rssi_echo [39:32], gap_bin_one [71:40],
  // gap_bin_two [103:72], gap_bin_three [135:104], gap_bin_four [167:136],
  // gap_bin_over [199:168], missed_total [231:200], since_last [263:232],
  // check_errors [295:264], rssi_average [307:296], zero [311:308]
  output logic [311:0] m_tdata
);
  import lslm_pkg::*;

  logic     in_valid;
  in_item_t in_item;
  logic     adv;
  result_t  stage_result;
  result_t  out_result;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.seq_number <= s_tdata[31:0];
      in_item.check_word <= s_tdata[63:32];
      in_item.rssi       <= s_tdata[71:64];
    end
  end

  lslm_stats u_stats (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .item   (in_item),
    .result (stage_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result <= stage_result;
    end
  end

  assign m_tdata = {4'b0000,
                    out_result.rssi_average,
                    out_result.check_errors,
                    out_result.since_last,
                    out_result.missed_total,
                    out_result.gap_bin_over,
                    out_result.gap_bin_four,
                    out_result.gap_bin_three,
                    out_result.gap_bin_two,
                    out_result.gap_bin_one,
                    out_result.rssi_echo,
                    out_result.expected_before};

endmodule
